// ----- sv/assert_macros.svh -----
// assertion macros shared by the rtl files
// no dependencies; expects clk and rst in the including module's scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_COMB(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent sequence starts in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) else $error(msg);

`endif

// ----- sv/imu_pkg.sv -----
// shared constants, types and helper functions of the ising metropolis update core
// no dependencies
`timescale 1ns / 1ps

package imu_pkg;

  // lattice geometry
  localparam int SIDE  = 64;
  localparam int SITES = SIDE * SIDE;
  localparam int CW    = (SIDE > 1) ? $clog2(SIDE) : 1;

  // internal widths of the running totals (signed, exact for any lattice size)
  localparam int EW = $clog2(2 * SITES) + 2;
  localparam int MW = $clog2(SITES) + 2;

  // port field widths
  localparam int COORD_W = 6;
  localparam int RND_W   = 16;
  localparam int TH_W    = 17;
  localparam int DE_W    = 5;
  localparam int TE_W    = 15;
  localparam int AM_W    = 13;

  // reset values
  localparam logic signed [EW-1:0] ENERGY_RESET = EW'(-2 * SITES);
  localparam logic signed [MW-1:0] MAGNET_RESET = MW'(SITES);
  localparam logic [TH_W-1:0]      THRESH_FOUR_RESET  = TH_W'(1200);
  localparam logic [TH_W-1:0]      THRESH_EIGHT_RESET = TH_W'(22);

  // configuration register indexes
  typedef enum logic {
    CFG_THRESH_FOUR  = 1'b0,
    CFG_THRESH_EIGHT = 1'b1
  } cfg_reg_t;

  // item opcodes
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_TRIAL = 1'b1
  } op_t;

  // which lattice row the datapath reads
  typedef enum logic [1:0] {
    RD_NONE = 2'b00,
    RD_UP   = 2'b01,
    RD_DN   = 2'b10,
    RD_MID  = 2'b11
  } rd_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic    cap_in;
    rd_sel_t rd;
    logic    eval;
  } cmd_t;

  // coordinate folded onto the lattice (small table for a 6 bit value)
  function automatic logic [CW-1:0] wrap_coord(logic [COORD_W-1:0] v);
    return CW'(v % SIDE);
  endfunction

  // energy clamped to the output field
  function automatic logic signed [TE_W-1:0] sat_energy(logic signed [EW-1:0] e);
    int ev;
    ev = int'(e);
    if (ev < -16384) ev = -16384;
    if (ev > 16383) ev = 16383;
    return TE_W'(ev);
  endfunction

  // magnitude of the magnetization clamped to the output field
  function automatic logic [AM_W-1:0] sat_mag(logic signed [MW-1:0] m);
    int mv;
    mv = int'(m);
    if (mv < 0) mv = -mv;
    if (mv > 8191) mv = 8191;
    return AM_W'(mv);
  endfunction

endpackage

// ----- sv/imu_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module imu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/imu_ctrl.sv -----
// sequencing state machine of the ising metropolis update core
// depends on imu_pkg
`timescale 1ns / 1ps

module imu_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output imu_pkg::cmd_t cmd
);

  import imu_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_UP   = 5'b00010,
    S_DN   = 5'b00100,
    S_MID  = 5'b01000,
    S_EVAL = 5'b10000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '{cap_in: 1'b0, rd: RD_NONE, eval: 1'b0};
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.cap_in = 1'b1;
          state_next = S_UP;
        end
      end
      S_UP: begin
        cmd.rd     = RD_UP;
        state_next = S_DN;
      end
      S_DN: begin
        cmd.rd     = RD_DN;
        state_next = S_MID;
      end
      S_MID: begin
        cmd.rd     = RD_MID;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ----- sv/imu_datapath.sv -----
// lattice row store, neighbour gather, acceptance test and running totals
// depends on imu_pkg and imu_ram
`timescale 1ns / 1ps

module imu_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  imu_pkg::cmd_t                     cmd,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [imu_pkg::TH_W-1:0]          cfg_data,
  input  logic                              opcode,
  input  logic [imu_pkg::COORD_W-1:0]       row,
  input  logic [imu_pkg::COORD_W-1:0]       col,
  input  logic                              spin_up,
  input  logic [imu_pkg::RND_W-1:0]         rand_uniform,
  output logic                              done,
  output logic                              accepted,
  output logic signed [imu_pkg::DE_W-1:0]   energy_change,
  output logic signed [imu_pkg::TE_W-1:0]   total_energy,
  output logic [imu_pkg::AM_W-1:0]          abs_magnetization
);

  import imu_pkg::*;

  // item registers
  logic            op_q;
  logic [CW-1:0]   r_q;
  logic [CW-1:0]   c_q;
  logic            spin_up_q;
  logic [RND_W-1:0] rnd_q;

  // configuration and totals
  logic [TH_W-1:0]        thresh_four;
  logic [TH_W-1:0]        thresh_eight;
  logic signed [EW-1:0]   energy;
  logic signed [MW-1:0]   magnet;
  logic signed [EW-1:0]   energy_next;
  logic signed [MW-1:0]   magnet_next;

  // row store and per row valid bits (unwritten rows read as all up)
  logic [SIDE-1:0] row_valid;
  logic            valid_q;
  rd_sel_t         last_rd;
  logic [CW-1:0]   rd_addr;
  logic [SIDE-1:0] ram_q;
  logic [SIDE-1:0] q_row;
  logic [SIDE-1:0] up_row;
  logic [SIDE-1:0] dn_row;
  logic [SIDE-1:0] new_row;

  // neighbour coordinates
  logic [CW-1:0] r_up, r_dn, c_lf, c_rt;

  // evaluation
  logic              s_bit;
  logic [2:0]        n_up;
  logic [DE_W-1:0]   de_raw;
  logic signed [DE_W-1:0] de;
  logic signed [DE_W-1:0] de_out;
  logic              flip;

  // capture the item on a start transfer
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      op_q      <= opcode;
      r_q       <= wrap_coord(row);
      c_q       <= wrap_coord(col);
      spin_up_q <= spin_up;
      rnd_q     <= rand_uniform;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh_four  <= THRESH_FOUR_RESET;
      thresh_eight <= THRESH_EIGHT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_THRESH_FOUR) begin
        thresh_four <= cfg_data;
      end else begin
        thresh_eight <= cfg_data;
      end
    end
  end

  // periodic neighbour rows and columns
  assign r_up = (r_q == '0) ? CW'(SIDE - 1) : r_q - 1'b1;
  assign r_dn = (r_q == CW'(SIDE - 1)) ? '0 : r_q + 1'b1;
  assign c_lf = (c_q == '0) ? CW'(SIDE - 1) : c_q - 1'b1;
  assign c_rt = (c_q == CW'(SIDE - 1)) ? '0 : c_q + 1'b1;

  // read address select
  always_comb begin
    case (cmd.rd)
      RD_UP:   rd_addr = r_up;
      RD_DN:   rd_addr = r_dn;
      RD_MID:  rd_addr = r_q;
      default: rd_addr = r_q;
    endcase
  end

  imu_ram #(
    .WIDTH(SIDE),
    .DEPTH(SIDE)
  ) u_rows (
    .clk  (clk),
    .we   (cmd.eval && flip),
    .waddr(r_q),
    .wdata(new_row),
    .re   (cmd.rd != RD_NONE),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  // valid bit and read tag follow the registered read data
  always_ff @(posedge clk) begin
    if (rst) begin
      last_rd <= RD_NONE;
    end else begin
      last_rd <= cmd.rd;
    end
  end

  always_ff @(posedge clk) begin
    valid_q <= row_valid[rd_addr];
  end

  assign q_row = valid_q ? ram_q : '1;

  // hold the neighbour rows
  always_ff @(posedge clk) begin
    if (last_rd == RD_UP) begin
      up_row <= q_row;
    end
    if (last_rd == RD_DN) begin
      dn_row <= q_row;
    end
  end

  // energy change and acceptance
  always_comb begin
    s_bit  = q_row[c_q];
    n_up   = 3'(up_row[c_q]) + 3'(dn_row[c_q]) + 3'(q_row[c_lf]) + 3'(q_row[c_rt]);
    de_raw = {n_up, 2'b00} - DE_W'(8);
    de     = s_bit ? signed'(de_raw) : signed'(DE_W'(0) - de_raw);
    if (op_q == OP_LOAD) begin
      flip   = (spin_up_q != s_bit);
      de_out = flip ? de : '0;
    end else begin
      de_out = de;
      if (de <= 0) begin
        flip = 1'b1;
      end else if (de == DE_W'(4)) begin
        flip = ({1'b0, rnd_q} <= thresh_four);
      end else begin
        flip = ({1'b0, rnd_q} <= thresh_eight);
      end
    end
    new_row      = q_row;
    new_row[c_q] = ~s_bit;
  end

  // updated totals
  always_comb begin
    energy_next = energy;
    magnet_next = magnet;
    if (flip) begin
      energy_next = energy + EW'(de);
      magnet_next = s_bit ? magnet - MW'(2) : magnet + MW'(2);
    end
  end

  // state update at evaluation
  always_ff @(posedge clk) begin
    if (rst) begin
      energy    <= ENERGY_RESET;
      magnet    <= MAGNET_RESET;
      row_valid <= '0;
    end else if (cmd.eval) begin
      energy <= energy_next;
      magnet <= magnet_next;
      if (flip) begin
        row_valid[r_q] <= 1'b1;
      end
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.eval;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      accepted          <= flip;
      energy_change     <= de_out;
      total_energy      <= sat_energy(energy_next);
      abs_magnetization <= sat_mag(magnet_next);
    end
  end

endmodule

// ----- sv/ising_metropolis_update_core.sv -----
// top level of the ising metropolis update core
// depends on imu_pkg, imu_ctrl, imu_datapath (and imu_ram below it)
//
// channel   direction  transfer condition
// -------   ---------  ---------------------------------------------
// item      in         start high and busy low at a rising edge
// result    out        done high for one cycle, cannot be held off
// config    in         cfg_we high at a rising edge, no wait
//
// each item runs from its start transfer through the up, down, site and
// evaluate states to its done strobe: the row store has one read port, so
// the up, down and site rows are read in turn, then evaluate writes the site
// row back on a flip. busy stays high from the cycle after the start transfer
// until done shows. reset is synchronous; rows unwritten since reset read as
// all spins up via per row valid bits, so no clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ising_metropolis_update_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [imu_pkg::TH_W-1:0]          cfg_data,
  input  logic                              opcode,
  input  logic [imu_pkg::COORD_W-1:0]       row,
  input  logic [imu_pkg::COORD_W-1:0]       col,
  input  logic                              spin_up,
  input  logic [imu_pkg::RND_W-1:0]         rand_uniform,
  output logic                              done,
  output logic                              accepted,
  output logic signed [imu_pkg::DE_W-1:0]   energy_change,
  output logic signed [imu_pkg::TE_W-1:0]   total_energy,
  output logic [imu_pkg::AM_W-1:0]          abs_magnetization
);

  import imu_pkg::*;

  cmd_t cmd;

  // sequencer
  imu_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .cmd  (cmd)
  );

  // datapath
  imu_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .opcode           (opcode),
    .row              (row),
    .col              (col),
    .spin_up          (spin_up),
    .rand_uniform     (rand_uniform),
    .done             (done),
    .accepted         (accepted),
    .energy_change    (energy_change),
    .total_energy     (total_energy),
    .abs_magnetization(abs_magnetization)
  );

  // item latency and result framing
  `ASSERT_NEXT(a_start_busy, start && !busy, busy, "busy not raised after start transfer")
  `ASSERT_NEXT(a_latency, start && !busy, ##4 done, "result not delivered five cycles after start")
  `ASSERT_COMB(a_done_idle, !done || !busy, "result strobe while an item is still in work")

endmodule

// ----- bench/tb_ising_metropolis_update_core.sv -----
`timescale 1ns / 1ps
// self-checking testbench for ising_metropolis_update_core: directed and random loads and trials
// depends on imu_pkg and the core rtl; each transfer is predicted from a private lattice copy

module tb_ising_metropolis_update_core;
  import imu_pkg::*;

  // one lattice command as the driver presents it
  typedef struct {
    op_t                op;
    logic [COORD_W-1:0] r;
    logic [COORD_W-1:0] c;
    logic               up;
    logic [RND_W-1:0]   rnd;
    int                 gap;
  } lattice_op_t;

  // one predicted update result
  typedef struct {
    logic                   acc;
    logic signed [DE_W-1:0] de;
    logic signed [TE_W-1:0] te;
    logic [AM_W-1:0]        am;
  } update_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       cfg_we = 1'b0;
  logic                       cfg_index = 1'b0;
  logic [TH_W-1:0]            cfg_data = '0;
  logic                       opcode = 1'b0;
  logic [COORD_W-1:0]         row = '0;
  logic [COORD_W-1:0]         col = '0;
  logic                       spin_up = 1'b0;
  logic [RND_W-1:0]           rand_uniform = '0;
  logic                       done;
  logic                       accepted;
  logic signed [DE_W-1:0]     energy_change;
  logic signed [TE_W-1:0]     total_energy;
  logic [AM_W-1:0]            abs_magnetization;

  // predictor state: lattice, running totals, acceptance thresholds
  bit              lattice_up [SIDE][SIDE];
  int              energy_now = -2 * SITES;
  int              magnet_now = SITES;
  logic [TH_W-1:0] thr_four = 17'd1200;
  logic [TH_W-1:0] thr_eight = 17'd22;

  lattice_op_t    pending_ops [$];
  update_result_t results_due [$];
  int             gap_left = 0;
  int             fail_count = 0;

  // threshold settings of the random phases; phase four ignores its entries and draws both at random
  int unsigned plan_four  [6] = '{65536, 0, 32768, 131071, 0, 20000};
  int unsigned plan_eight [6] = '{65536, 0, 4000, 22, 0, 3000};

  ising_metropolis_update_core dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .opcode            (opcode),
    .row               (row),
    .col               (col),
    .spin_up           (spin_up),
    .rand_uniform      (rand_uniform),
    .done              (done),
    .accepted          (accepted),
    .energy_change     (energy_change),
    .total_energy      (total_energy),
    .abs_magnetization (abs_magnetization)
  );

  always #5 clk = ~clk;

  // spin value of one predicted site
  function automatic int spin_of(int r, int c);
    return lattice_up[r][c] ? 1 : -1;
  endfunction

  // metropolis update of the private lattice, returns the expected result
  function automatic update_result_t metropolis_predict(op_t op, logic [COORD_W-1:0] r_in,
      logic [COORD_W-1:0] c_in, logic up, logic [RND_W-1:0] rnd);
    int r, c, s, nsum, de, e_out, m_out;
    bit flip;
    update_result_t res;
    r = int'(r_in) % SIDE;
    c = int'(c_in) % SIDE;
    s = spin_of(r, c);
    nsum = spin_of((r + SIDE - 1) % SIDE, c) + spin_of((r + 1) % SIDE, c) +
           spin_of(r, (c + SIDE - 1) % SIDE) + spin_of(r, (c + 1) % SIDE);
    de = 2 * s * nsum;
    if (op == OP_LOAD) begin
      flip = ((up ? 1 : -1) != s);
      if (!flip) de = 0;
    end else if (de <= 0) begin
      flip = 1'b1;
    end else if (de == 4) begin
      flip = ({1'b0, rnd} <= thr_four);
    end else begin
      flip = ({1'b0, rnd} <= thr_eight);
    end
    if (flip) begin
      lattice_up[r][c] = (s < 0);
      energy_now += de;
      magnet_now -= 2 * s;
    end
    // output fields saturate, totals stay exact
    e_out = energy_now;
    if (e_out < -16384) e_out = -16384;
    if (e_out > 16383) e_out = 16383;
    m_out = (magnet_now < 0) ? -magnet_now : magnet_now;
    if (m_out > 8191) m_out = 8191;
    res.acc = flip;
    res.de = DE_W'(de);
    res.te = TE_W'(e_out);
    res.am = AM_W'(m_out);
    return res;
  endfunction

  // idle cycles after a transfer: mostly short, a few long
  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return 0;
    if (pick < 75) return $urandom_range(1, 5);
    if (pick < 95) return $urandom_range(6, 12);
    return $urandom_range(20, 80);
  endfunction

  // random value right around a threshold
  function automatic logic [RND_W-1:0] rnd_near(logic [TH_W-1:0] t);
    int v;
    v = int'(t) + $urandom_range(0, 2) - 1;
    if (v < 0) v = 0;
    if (v > 2**RND_W - 1) v = 2**RND_W - 1;
    return RND_W'(v);
  endfunction

  task automatic add_op(op_t op, int r, int c, bit up, int rnd);
    lattice_op_t o;
    o.op = op;
    o.r = COORD_W'(r);
    o.c = COORD_W'(c);
    o.up = up;
    o.rnd = RND_W'(rnd);
    o.gap = idle_gap();
    pending_ops.push_back(o);
  endtask

  // random commands, mostly inside a small moving window so spins interact
  task automatic fill_random(int n, bit quiet);
    lattice_op_t o;
    int base_r, base_c;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        base_r = ($urandom_range(0, 3) == 0) ? SIDE - 2 : $urandom_range(0, SIDE - 1);
        base_c = ($urandom_range(0, 3) == 0) ? SIDE - 2 : $urandom_range(0, SIDE - 1);
      end
      o.op = ($urandom_range(0, 9) < 3) ? OP_LOAD : OP_TRIAL;
      if ($urandom_range(0, 9) < 7) begin
        o.r = COORD_W'((base_r + $urandom_range(0, 3)) % SIDE);
        o.c = COORD_W'((base_c + $urandom_range(0, 3)) % SIDE);
      end else begin
        o.r = COORD_W'($urandom_range(0, 2**COORD_W - 1));
        o.c = COORD_W'($urandom_range(0, 2**COORD_W - 1));
      end
      o.up = $urandom_range(0, 1);
      case ($urandom_range(0, 9))
        0: o.rnd = '0;
        1: o.rnd = '1;
        2: o.rnd = rnd_near(thr_four);
        3: o.rnd = rnd_near(thr_eight);
        default: o.rnd = RND_W'($urandom_range(0, 2**RND_W - 1));
      endcase
      o.gap = quiet ? 0 : idle_gap();
      pending_ops.push_back(o);
    end
  endtask

  // register write while the core is idle
  task automatic write_reg(cfg_reg_t idx, logic [TH_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_THRESH_FOUR) thr_four = val;
    else thr_eight = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold until every command is sent and every result has come, plus settling time
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_ops.size() > 0 || start || results_due.size() > 0);
    repeat (8) @(posedge clk);
  endtask

  // driver: start stays high back to back unless an idle gap is pending
  always @(posedge clk) begin
    lattice_op_t nxt;
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy)
        results_due.push_back(metropolis_predict(op_t'(opcode), row, col, spin_up,
                                                 rand_uniform));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          nxt = pending_ops.pop_front();
          opcode <= nxt.op;
          row <= nxt.r;
          col <= nxt.c;
          spin_up <= nxt.up;
          rand_uniform <= nxt.rnd;
          start <= 1'b1;
          gap_left = nxt.gap;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: each done strobe is one result transfer
  always @(posedge clk) begin
    update_result_t want;
    if (!rst && done) begin
      if (results_due.size() == 0) begin
        $error("result transfer with no command outstanding");
        fail_count++;
      end else begin
        want = results_due.pop_front();
        if (accepted !== want.acc) begin
          $error("accepted: expected %0d, got %0d", want.acc, accepted);
          fail_count++;
        end
        if (energy_change !== want.de) begin
          $error("energy_change: expected %0d, got %0d", want.de, energy_change);
          fail_count++;
        end
        if (total_energy !== want.te) begin
          $error("total_energy: expected %0d, got %0d", want.te, total_energy);
          fail_count++;
        end
        if (abs_magnetization !== want.am) begin
          $error("abs_magnetization: expected %0d, got %0d", want.am, abs_magnetization);
          fail_count++;
        end
      end
    end
  end

  // run limit
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // stimulus sequence
  initial begin
    for (int r = 0; r < SIDE; r++)
      for (int c = 0; c < SIDE; c++)
        lattice_up[r][c] = 1'b1;

    // directed part at reset thresholds
    add_op(OP_TRIAL, 0, 0, 1'b0, 0);            // rise of eight, accepted at lowest random
    add_op(OP_TRIAL, 0, 63, 1'b1, 65535);       // rise of four, rejected
    add_op(OP_TRIAL, 63, 0, 1'b0, 1200);        // rise of four, random equal to threshold
    add_op(OP_TRIAL, 0, 0, 1'b1, 65535);        // drop in energy always taken
    add_op(OP_LOAD, 5, 5, 1'b1, 0);             // load of an equal spin
    add_op(OP_LOAD, 5, 5, 1'b0, 65535);         // load of a different spin
    add_op(OP_LOAD, 5, 5, 1'b1, 21845);
    add_op(OP_LOAD, 10, 9, 1'b0, 0);
    add_op(OP_LOAD, 10, 11, 1'b0, 0);
    add_op(OP_TRIAL, 10, 10, 1'b0, 65535);      // zero change always taken
    add_op(OP_TRIAL, 20, 20, 1'b1, 23);         // rise of eight just above threshold
    add_op(OP_TRIAL, 20, 20, 1'b0, 22);         // rise of eight at threshold
    add_op(OP_TRIAL, 20, 21, 1'b1, 1201);       // rise of four just above threshold
    add_op(OP_LOAD, 63, 63, 1'b0, 65535);
    add_op(OP_TRIAL, 63, 63, 1'b1, 21845);      // corner site wraps both ways
    add_op(OP_TRIAL, 42, 21, 1'b0, 43690);
    add_op(OP_LOAD, 21, 42, 1'b1, 21845);
    add_op(OP_TRIAL, 62, 1, 1'b1, 0);
    add_op(OP_LOAD, 63, 0, 1'b1, 43690);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait_quiet();

    for (int p = 0; p < 6; p++) begin
      if (p == 4) begin
        write_reg(CFG_THRESH_FOUR, TH_W'($urandom_range(0, 2**TH_W - 1)));
        write_reg(CFG_THRESH_EIGHT, TH_W'($urandom_range(0, 2**TH_W - 1)));
      end else begin
        write_reg(CFG_THRESH_FOUR, TH_W'(plan_four[p]));
        write_reg(CFG_THRESH_EIGHT, TH_W'(plan_eight[p]));
      end
      fill_random(230, p == 2);
      wait_quiet();
    end

    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/imu_pkg.sv
sv/imu_ram.sv
sv/imu_ctrl.sv
sv/imu_datapath.sv
sv/ising_metropolis_update_core.sv
bench/tb_ising_metropolis_update_core.sv
